>>> rtl/core/damped_oscillator_ssm_imex_step_macros.svh
// Assertion macros for the damped oscillator step block
`ifndef DAMPED_OSCILLATOR_SSM_IMEX_STEP_MACROS_SVH
`define DAMPED_OSCILLATOR_SSM_IMEX_STEP_MACROS_SVH
`ifndef SYNTHESIS
`define DOS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define DOS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define DOS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define DOS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/core/dos_pkg.sv
// Shared types and constants for the damped oscillator step block
package dos_pkg;
  localparam int Channels = 64;
  localparam int ChW = 6;
  localparam int FracBits = 24;
  localparam logic [24:0] DtMinReset = 25'd17;
  localparam logic [30:0] DtMaxReset = 31'(1 << FracBits);
  localparam logic [24:0] SMinReset = 25'd17;
  localparam logic [1:0] RegDtMin = 2'd0;
  localparam logic [1:0] RegDtMax = 2'd1;
  localparam logic [1:0] RegSMin = 2'd2;

  localparam logic [3:0] OpDtSq = 4'd0;
  localparam logic [3:0] OpStab = 4'd1;
  localparam logic [3:0] OpDamp = 4'd2;
  localparam logic [3:0] OpCombRe = 4'd3;
  localparam logic [3:0] OpCombIm = 4'd4;
  localparam logic [3:0] OpVelRe = 4'd5;
  localparam logic [3:0] OpSumRe = 4'd6;
  localparam logic [3:0] OpVelIm = 4'd7;
  localparam logic [3:0] OpSumIm = 4'd8;

  typedef struct packed {
    logic [5:0] channel;
    logic first;
    logic signed [31:0] a_coef;
    logic signed [31:0] g_coef;
    logic signed [31:0] dt_raw;
    logic signed [31:0] drive_real;
    logic signed [31:0] drive_imag;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] vel_real;
    logic signed [31:0] vel_imag;
    logic signed [31:0] pos_real;
    logic signed [31:0] pos_imag;
  } out_item_t;

  typedef struct packed {
    logic start;
    logic signed [31:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic signed [31:0] quo;
  } div_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (v < -34'sh0_8000_0000) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction
endpackage

>>> rtl/core/dos_divider.sv
// Restoring divider: round((num << FracBits) / den), half away from zero, saturated
module dos_divider (
  input  logic clk,
  input  logic rst_n,
  input  dos_pkg::div_req_t req,
  output dos_pkg::div_rsp_t rsp
);
  localparam int NW = 32 + dos_pkg::FracBits;
  logic [NW-1:0] num_r, num_nxt;
  logic [NW-1:0] quo_r, quo_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] den_r;
  logic neg_r;
  logic [6:0] cnt_r;
  logic busy_r, done_r;
  logic [33:0] trial;
  logic [NW:0] rq;
  logic [33:0] twice;
  logic signed [33:0] sq;

  always_comb begin
    rem_nxt = {rem_r[31:0], num_r[NW-1]};
    num_nxt = {num_r[NW-2:0], 1'b0};
    trial = {1'b0, rem_nxt} - {2'b0, den_r};
    quo_nxt = {quo_r[NW-2:0], ~trial[33]};
    if (!trial[33]) rem_nxt = trial[32:0];
    twice = {rem_r, 1'b0};
    rq = {1'b0, quo_r} + ((twice >= {2'b0, den_r}) ? (NW+1)'(1) : (NW+1)'(0));
    if (rq > (NW+1)'(34'h0_8000_0000)) sq = 34'sh0_8000_0000;
    else sq = $signed({1'b0, rq[32:0]});
    if (neg_r) sq = -sq;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r <= 7'(NW);
        neg_r <= req.num[31];
        num_r <= NW'($unsigned(req.num[31] ? -req.num : req.num)) << dos_pkg::FracBits;
        den_r <= req.den;
        rem_r <= '0;
        quo_r <= '0;
      end else if (busy_r) begin
        num_r <= num_nxt;
        rem_r <= rem_nxt;
        quo_r <= quo_nxt;
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo = dos_pkg::sat32(sq);
endmodule

>>> rtl/core/damped_oscillator_ssm_imex_step.sv
// Top level: damped oscillator IMEX step with shared multiplier and divider
//   channel | direction | handshake        | payload
//   in_     | input     | valid / stall    | dos_pkg::in_item_t
//   out_    | output    | valid / stall    | dos_pkg::out_item_t
//   cfg_    | input     | valid / ready    | index, data
// One transaction reads its channel state, then runs 9 multiplies on one shared
// multiplier, then two 56-step divisions on the shared divider, then presents the
// result and returns to idle.
// Reset clears state memory by a pass over all 64 channels; no item is taken meanwhile.
// A stalled result holds; the next item is taken once it is delivered.
`include "damped_oscillator_ssm_imex_step_macros.svh"
module damped_oscillator_ssm_imex_step (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  dos_pkg::in_item_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output dos_pkg::out_item_t out_data,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [31:0] cfg_data
);
  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_RD, S_MUL, S_DIV, S_DIVW, S_OUT
  } state_t;

  state_t state_r;
  logic [24:0] dt_min_r, s_min_r;
  logic [30:0] dt_max_r;
  logic [63:0] vel_mem [dos_pkg::Channels];
  logic [63:0] pos_mem [dos_pkg::Channels];
  logic [63:0] vel_q_r, pos_q_r;
  logic [5:0] clr_r;
  dos_pkg::in_item_t item_r;
  logic signed [31:0] dt_r, dt2_r, s_r, damp_r, xr_r, xi_r, wr_r, wi_r;
  logic signed [31:0] cr_r, ci_r, tr_r, ti_r, nwr_r;
  logic [3:0] op_r;
  logic div_im_r;
  logic signed [31:0] ma, mb, mres;
  logic signed [63:0] prod;
  logic [63:0] pmag, prnd;
  logic signed [33:0] pr;
  logic signed [31:0] dtc;
  logic signed [31:0] smin_v;
  dos_pkg::div_req_t dreq;
  dos_pkg::div_rsp_t drsp;
  dos_pkg::out_item_t out_r;

  dos_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  always_comb begin
    ma = '0; mb = '0;
    case (op_r)
      dos_pkg::OpDtSq: begin ma = dt_r; mb = dt_r; end
      dos_pkg::OpStab: begin ma = dt2_r; mb = item_r.a_coef; end
      dos_pkg::OpDamp: begin ma = dt_r; mb = item_r.g_coef; end
      dos_pkg::OpCombRe: begin ma = item_r.a_coef; mb = xr_r; end
      dos_pkg::OpCombIm: begin ma = item_r.a_coef; mb = xi_r; end
      dos_pkg::OpVelRe: begin ma = damp_r; mb = wr_r; end
      dos_pkg::OpSumRe: begin ma = dt2_r; mb = cr_r; end
      dos_pkg::OpVelIm: begin ma = damp_r; mb = wi_r; end
      dos_pkg::OpSumIm: begin ma = dt2_r; mb = ci_r; end
      default: begin ma = '0; mb = '0; end
    endcase
    prod = ma * mb;
    pmag = prod[63] ? 64'(-prod) : 64'(prod);
    prnd = (pmag + (64'd1 << (dos_pkg::FracBits - 1))) >> dos_pkg::FracBits;
    if (prnd > 64'h8000_0000) pr = 34'sh0_8000_0000;
    else pr = $signed({1'b0, prnd[32:0]});
    if (prod[63]) pr = -pr;
    mres = dos_pkg::sat32(pr);
    dtc = item_r.dt_raw;
    if ($signed({dtc[31], dtc}) < $signed({8'b0, dt_min_r})) dtc = 32'({7'b0, dt_min_r});
    if ($signed({dtc[31], dtc}) > $signed({2'b0, dt_max_r})) dtc = 32'({1'b0, dt_max_r});
    smin_v = (s_min_r == '0) ? 32'sd1 : 32'({7'b0, s_min_r});
    dreq.start = (state_r == S_DIV);
    dreq.num = div_im_r ? ti_r : tr_r;
    dreq.den = s_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r <= '0;
      dt_min_r <= dos_pkg::DtMinReset;
      dt_max_r <= dos_pkg::DtMaxReset;
      s_min_r <= dos_pkg::SMinReset;
      op_r <= '0;
      div_im_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          dos_pkg::RegDtMin: dt_min_r <= cfg_data[24:0];
          dos_pkg::RegDtMax: dt_max_r <= cfg_data[30:0];
          dos_pkg::RegSMin: s_min_r <= cfg_data[24:0];
          default: ;
        endcase
      end
      case (state_r)
        S_CLR: begin
          clr_r <= clr_r + 6'd1;
          if (clr_r == 6'(dos_pkg::Channels - 1)) state_r <= S_IDLE;
        end
        S_IDLE: if (in_valid) begin
          item_r <= in_data;
          state_r <= S_RD;
        end
        S_RD: begin
          dt_r <= dtc;
          xr_r <= item_r.first ? '0 : pos_q_r[31:0];
          xi_r <= item_r.first ? '0 : pos_q_r[63:32];
          wr_r <= item_r.first ? '0 : vel_q_r[31:0];
          wi_r <= item_r.first ? '0 : vel_q_r[63:32];
          op_r <= dos_pkg::OpDtSq;
          state_r <= S_MUL;
        end
        S_MUL: begin
          op_r <= op_r + 4'd1;
          case (op_r)
            dos_pkg::OpDtSq: dt2_r <= mres;
            dos_pkg::OpStab: begin
              s_r <= (dos_pkg::sat32(34'(1 << dos_pkg::FracBits) + 34'(mres)) < smin_v)
                ? smin_v : dos_pkg::sat32(34'(1 << dos_pkg::FracBits) + 34'(mres));
            end
            dos_pkg::OpDamp: damp_r <= dos_pkg::sat32(34'(1 << dos_pkg::FracBits) - 34'(mres));
            dos_pkg::OpCombRe: cr_r <= dos_pkg::sat32(34'(item_r.drive_real) - 34'(mres));
            dos_pkg::OpCombIm: ci_r <= dos_pkg::sat32(34'(item_r.drive_imag) - 34'(mres));
            dos_pkg::OpVelRe: tr_r <= mres;
            dos_pkg::OpSumRe: tr_r <= dos_pkg::sat32(34'(tr_r) + 34'(mres));
            dos_pkg::OpVelIm: ti_r <= mres;
            dos_pkg::OpSumIm: begin
              ti_r <= dos_pkg::sat32(34'(ti_r) + 34'(mres));
              div_im_r <= 1'b0;
              state_r <= S_DIV;
            end
            default: state_r <= S_DIV;
          endcase
        end
        S_DIV: state_r <= S_DIVW;
        S_DIVW: if (drsp.done) begin
          if (!div_im_r) begin
            nwr_r <= drsp.quo;
            div_im_r <= 1'b1;
            state_r <= S_DIV;
          end else begin
            out_r.vel_real <= nwr_r;
            out_r.vel_imag <= drsp.quo;
            out_r.pos_real <= dos_pkg::sat32(34'(xr_r) + 34'(nwr_r));
            out_r.pos_imag <= dos_pkg::sat32(34'(xi_r) + 34'(drsp.quo));
            state_r <= S_OUT;
          end
        end
        S_OUT: if (!out_stall) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_CLR) begin
      vel_mem[clr_r] <= '0;
      pos_mem[clr_r] <= '0;
    end else if (state_r == S_OUT && !out_stall) begin
      vel_mem[item_r.channel] <= {out_r.vel_imag, out_r.vel_real};
      pos_mem[item_r.channel] <= {out_r.pos_imag, out_r.pos_real};
    end
    vel_q_r <= vel_mem[(state_r == S_IDLE) ? in_data.channel : item_r.channel];
    pos_q_r <= pos_mem[(state_r == S_IDLE) ? in_data.channel : item_r.channel];
  end

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_data = out_r;
  assign cfg_ready = 1'b1;

  `DOS_ASSERT_IMPL(a_out_not_idle, clk, rst_n, out_valid, in_stall)
  `DOS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))
  `DOS_ASSERT_NEXT(a_take_busy, clk, rst_n, in_valid && !in_stall, in_stall)
endmodule

>>> test/tb_damped_oscillator_ssm_imex_step.sv
// Testbench for the damped oscillator IMEX step: predicts each result and checks it field by field
module tb_damped_oscillator_ssm_imex_step;
  localparam longint QMAX = 64'sd2147483647;
  localparam longint QMIN = -64'sd2147483648;
  localparam longint CYCLE_LIMIT = 1500000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  dos_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  dos_pkg::out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = dos_pkg::RegDtMin;
  logic [31:0] cfg_data = '0;

  damped_oscillator_ssm_imex_step uut (.*);

  always #5 clk = ~clk;

  dos_pkg::in_item_t pending_items[$];
  dos_pkg::out_item_t expected_steps[$];
  int errors = 0;
  longint cycles = 0;
  bit no_idle = 1'b0;
  bit sender_hold = 1'b0;

  // predictor state
  longint dt_lo, dt_hi, s_floor;
  logic [31:0] vel_re[dos_pkg::Channels], vel_im[dos_pkg::Channels];
  logic [31:0] pos_re[dos_pkg::Channels], pos_im[dos_pkg::Channels];

  function automatic longint clip(longint v);
    if (v > QMAX) return QMAX;
    if (v < QMIN) return QMIN;
    return v;
  endfunction

  function automatic longint qmul(longint a, longint b);
    longint p, m, r;
    p = a * b;
    m = (p < 0) ? -p : p;
    r = (m + (64'sd1 <<< (dos_pkg::FracBits - 1))) >>> dos_pkg::FracBits;
    return clip((p < 0) ? -r : r);
  endfunction

  function automatic longint qdiv(longint n, longint d);
    longint m, q;
    m = (n < 0) ? -n : n;
    q = ((m <<< dos_pkg::FracBits) + d / 2) / d;
    if (q > QMAX + 1) q = QMAX + 1;
    return clip((n < 0) ? -q : q);
  endfunction

  function automatic dos_pkg::out_item_t advance_oscillator(dos_pkg::in_item_t it);
    dos_pkg::out_item_t r;
    longint a, g, dt, dt2, s, damp, comb, tw, nw[2], nx[2], w[2], x[2], bu[2];
    int ch;
    ch = int'(it.channel) % dos_pkg::Channels;
    a = it.a_coef; g = it.g_coef; dt = it.dt_raw;
    bu[0] = it.drive_real; bu[1] = it.drive_imag;
    if (it.first) begin
      vel_re[ch] = '0; vel_im[ch] = '0; pos_re[ch] = '0; pos_im[ch] = '0;
    end
    w[0] = longint'($signed(vel_re[ch])); w[1] = longint'($signed(vel_im[ch]));
    x[0] = longint'($signed(pos_re[ch])); x[1] = longint'($signed(pos_im[ch]));
    if (dt < dt_lo) dt = dt_lo;
    if (dt > dt_hi) dt = dt_hi;
    dt2 = qmul(dt, dt);
    s = clip((64'sd1 <<< dos_pkg::FracBits) + qmul(dt2, a));
    if (s < ((s_floor == 0) ? 1 : s_floor)) s = (s_floor == 0) ? 1 : s_floor;
    damp = clip((64'sd1 <<< dos_pkg::FracBits) - qmul(dt, g));
    for (int k = 0; k < 2; k++) begin
      comb = clip(bu[k] - qmul(a, x[k]));
      tw = clip(qmul(damp, w[k]) + qmul(dt2, comb));
      nw[k] = qdiv(tw, s);
      nx[k] = clip(x[k] + nw[k]);
    end
    vel_re[ch] = nw[0][31:0]; vel_im[ch] = nw[1][31:0];
    pos_re[ch] = nx[0][31:0]; pos_im[ch] = nx[1][31:0];
    r.vel_real = nw[0][31:0]; r.vel_imag = nw[1][31:0];
    r.pos_real = nx[0][31:0]; r.pos_imag = nx[1][31:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    errors++;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_steps.push_back(advance_oscillator(in_data));
        void'(pending_items.pop_front());
      end
      if (!in_valid || !in_stall) begin
        if (in_valid && !in_stall && pending_items.size() > 0 && !sender_hold &&
            (no_idle || $urandom_range(99) >= 22)) begin
          in_data <= pending_items[0];
          in_valid <= 1'b1;
        end else if (!(in_valid && !in_stall) && pending_items.size() > 0 && !sender_hold &&
                     (no_idle || $urandom_range(99) >= 22)) begin
          in_data <= pending_items[0];
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= !no_idle && ($urandom_range(99) < 22);
    end
  end

  // monitor
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout");
      $display("== FAIL ==");
      $finish;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (expected_steps.size() == 0) begin
        report_mismatch("unexpected transaction", out_data.vel_real, '0);
      end else begin
        dos_pkg::out_item_t e;
        e = expected_steps.pop_front();
        if (out_data.vel_real !== e.vel_real)
          report_mismatch("vel_real", out_data.vel_real, e.vel_real);
        if (out_data.vel_imag !== e.vel_imag)
          report_mismatch("vel_imag", out_data.vel_imag, e.vel_imag);
        if (out_data.pos_real !== e.pos_real)
          report_mismatch("pos_real", out_data.pos_real, e.pos_real);
        if (out_data.pos_imag !== e.pos_imag)
          report_mismatch("pos_imag", out_data.pos_imag, e.pos_imag);
      end
    end
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(1 << 25) - (1 << 24);
      3: return $urandom_range(1 << 20);
      default: return $urandom();
    endcase
  endfunction

  function automatic dos_pkg::in_item_t rand_item();
    dos_pkg::in_item_t it;
    it.channel = 6'($urandom_range(63));
    it.first = ($urandom_range(9) == 0);
    it.a_coef = rand_word();
    it.g_coef = rand_word();
    it.dt_raw = ($urandom_range(2) == 0) ? $urandom() : $urandom_range(1 << 24);
    it.drive_real = rand_word();
    it.drive_imag = rand_word();
    return it;
  endfunction

  task automatic wait_drained();
    while (pending_items.size() > 0 || in_valid || expected_steps.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      dos_pkg::RegDtMin: dt_lo = val & 32'h1FF_FFFF;
      dos_pkg::RegDtMax: dt_hi = val & 32'h7FFF_FFFF;
      default: s_floor = val & 32'h1FF_FFFF;
    endcase
  endtask

  task automatic random_run(int n);
    repeat (n) pending_items.push_back(rand_item());
    wait_drained();
  endtask

  initial begin
    dos_pkg::in_item_t it;
    dt_lo = dos_pkg::DtMinReset; dt_hi = dos_pkg::DtMaxReset; s_floor = dos_pkg::SMinReset;
    for (int c = 0; c < dos_pkg::Channels; c++) begin
      vel_re[c] = '0; vel_im[c] = '0; pos_re[c] = '0; pos_im[c] = '0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, negative step, overflow, channel 0 and 63
    it = '0; it.dt_raw = 32'h8000_0000; it.drive_real = 32'h7FFF_FFFF;
    it.drive_imag = 32'h8000_0000; pending_items.push_back(it);
    it = '1; it.first = 1'b0; pending_items.push_back(it);
    it = '0; it.channel = 6'd63; it.first = 1'b1; it.a_coef = 32'h8000_0000;
    it.g_coef = 32'h7FFF_FFFF; it.dt_raw = 32'h7FFF_FFFF;
    it.drive_real = 32'h0100_0000; pending_items.push_back(it);
    it.a_coef = 32'h7FFF_FFFF; it.g_coef = 32'h8000_0000; it.first = 1'b0;
    pending_items.push_back(it);
    for (int i = 0; i < 8; i++) begin
      it = rand_item(); it.channel = 6'd5; it.first = (i == 0);
      it.dt_raw = 32'h0040_0000; pending_items.push_back(it);
    end
    wait_drained();

    // inverted clamp, zero s_min, wide step range
    write_reg(dos_pkg::RegDtMin, 32'h0100_0000);
    write_reg(dos_pkg::RegDtMax, 32'h0000_1000);
    write_reg(dos_pkg::RegSMin, 32'h0);
    it = rand_item(); it.a_coef = 32'h8000_0000; pending_items.push_back(it);
    random_run(100);

    write_reg(dos_pkg::RegDtMin, 32'h0);
    write_reg(dos_pkg::RegDtMax, 32'h7FFF_FFFF);
    write_reg(dos_pkg::RegSMin, 32'h0100_0000);
    random_run(150);

    write_reg(dos_pkg::RegDtMin, 32'h01FF_FFFF);
    write_reg(dos_pkg::RegDtMax, 32'h0080_0000);
    write_reg(dos_pkg::RegSMin, 32'h1);
    no_idle = 1'b1;
    random_run(120);
    no_idle = 1'b0;

    write_reg(dos_pkg::RegDtMin, 32'd17);
    write_reg(dos_pkg::RegDtMax, 32'h0100_0000);
    write_reg(dos_pkg::RegSMin, 32'd17);
    repeat (100) pending_items.push_back(rand_item());
    while (pending_items.size() > 60) @(posedge clk);
    sender_hold = 1'b1;
    while (in_valid || expected_steps.size() > 0) @(posedge clk);
    sender_hold = 1'b0;
    wait_drained();
    random_run(120);

    if (errors == 0 && expected_steps.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

>>> damped_oscillator_ssm_imex_step.f
+incdir+rtl/core
rtl/core/dos_pkg.sv
rtl/core/dos_divider.sv
rtl/core/damped_oscillator_ssm_imex_step.sv
test/tb_damped_oscillator_ssm_imex_step.sv
